// File: rtl/obd2_round_robin_pid_poller_defines.svh
// Assertion macros used by the poller engine RTL.
// Define NO_ASSERTIONS to leave every checker out of the build.
`ifndef OBD2_ROUND_ROBIN_PID_POLLER_DEFINES_SVH
`define OBD2_ROUND_ROBIN_PID_POLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define OBD2RR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obd2rr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define OBD2RR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obd2rr: next-cycle check failed");

`else

`define OBD2RR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OBD2RR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/obd2rr_pkg.sv
`timescale 1ns / 1ps

package obd2rr_pkg;

    // Poll table geometry.
    localparam int POLL_ENTRIES_DEF = 10;
    localparam int POLL_IDX_W       = 4;

    // Protocol constants.
    localparam logic [7:0]  SVC_RESPONSE = 8'h41;
    localparam logic [7:0]  PCI_OVERHEAD = 8'h02;
    localparam logic [4:0]  HEADER_BYTES = 5'd3;
    localparam logic [15:0] FAIL_SAT     = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [2:0] CFG_REPLY_ID      = 3'd0;
    localparam logic [2:0] CFG_BACKOFF_MS    = 3'd1;
    localparam logic [2:0] CFG_MIN_GAP_MS    = 3'd2;
    localparam logic [2:0] CFG_REPLY_TMO_MS  = 3'd3;
    localparam logic [2:0] CFG_FAIL_LIMIT    = 3'd4;
    localparam logic [2:0] CFG_SILENCE_MS    = 3'd5;
    localparam logic [2:0] CFG_NO_REPLY_MS   = 3'd6;

    // Configuration reset values.
    localparam logic [10:0] RST_REPLY_ID     = 11'd2024;
    localparam logic [15:0] RST_BACKOFF_MS   = 16'd1000;
    localparam logic [15:0] RST_MIN_GAP_MS   = 16'd10;
    localparam logic [15:0] RST_REPLY_TMO_MS = 16'd100;
    localparam logic [15:0] RST_FAIL_LIMIT   = 16'd5;
    localparam logic [31:0] RST_SILENCE_MS   = 32'd5000;
    localparam logic [31:0] RST_NO_REPLY_MS  = 32'd15000;

    typedef struct packed {
        logic [10:0] reply_id;
        logic [15:0] backoff_ms;
        logic [15:0] min_gap_ms;
        logic [15:0] reply_timeout_ms;
        logic [15:0] fail_limit;
        logic [31:0] silence_ms;
        logic [31:0] no_reply_ms;
    } t_cfg;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        frame_present;
        logic [28:0] frame_ident;
        logic        frame_extended;
        logic        frame_remote;
        logic [3:0]  frame_bytes;
        logic [7:0]  pci_byte;
        logic [7:0]  service_byte;
        logic [7:0]  pid_byte;
        logic [31:0] frame_payload;
        logic        tx_accepted;
    } t_in_item;

    typedef struct packed {
        logic        tx_request;
        logic [7:0]  tx_pid;
        logic        reading_valid;
        logic [7:0]  reading_pid;
        logic [31:0] reading_payload;
        logic        link_lost;
        logic        ever_replied;
    } t_out_item;

    // PID polled at each table slot; the upper slots repeat the first six.
    function automatic logic [7:0] poll_pid(input logic [POLL_IDX_W-1:0] idx);
        logic [7:0] pid;
        case (idx)
            4'd0:    pid = 8'h0C;
            4'd1:    pid = 8'h0D;
            4'd2:    pid = 8'h05;
            4'd3:    pid = 8'h2F;
            4'd4:    pid = 8'h5E;
            4'd5:    pid = 8'h11;
            4'd6:    pid = 8'h04;
            4'd7:    pid = 8'h33;
            4'd8:    pid = 8'hA4;
            4'd9:    pid = 8'hA6;
            4'd10:   pid = 8'h0C;
            4'd11:   pid = 8'h0D;
            4'd12:   pid = 8'h05;
            4'd13:   pid = 8'h2F;
            4'd14:   pid = 8'h5E;
            4'd15:   pid = 8'h11;
            default: pid = 8'h00;
        endcase
        return pid;
    endfunction

    // Expected number of data bytes in the reply for each slot.
    function automatic logic [2:0] poll_len(input logic [POLL_IDX_W-1:0] idx);
        logic [2:0] len;
        case (idx)
            4'd0, 4'd4, 4'd10, 4'd14: len = 3'd2;
            4'd8, 4'd9:               len = 3'd4;
            default:                  len = 3'd1;
        endcase
        return len;
    endfunction

    // Keeps the leading data bytes of a reply and clears the unused low bytes.
    function automatic logic [31:0] payload_mask(input logic [2:0] len);
        logic [31:0] mask;
        case (len)
            3'd1:    mask = 32'hFF00_0000;
            3'd2:    mask = 32'hFFFF_0000;
            3'd3:    mask = 32'hFFFF_FF00;
            default: mask = 32'hFFFF_FFFF;
        endcase
        return mask;
    endfunction

endpackage

// File: rtl/obd2rr_engine.sv
`timescale 1ns / 1ps
`include "obd2_round_robin_pid_poller_defines.svh"

module obd2rr_engine #(
    parameter int POLL_ENTRIES = obd2rr_pkg::POLL_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  obd2rr_pkg::t_in_item i_item,
    input  obd2rr_pkg::t_cfg     i_cfg,
    output obd2rr_pkg::t_out_item o_result
);

    localparam int IDX_W = obd2rr_pkg::POLL_IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POLL_ENTRIES - 1);

    // Poller state.
    logic [IDX_W-1:0] r_poll_index, n_poll_index;
    logic             r_awaiting, n_awaiting;
    logic [31:0]      r_requested_at, n_requested_at;
    logic [15:0]      r_fail_count, n_fail_count;
    logic [31:0]      r_last_attempt_at, n_last_attempt_at;
    logic [31:0]      r_last_reply_at, n_last_reply_at;
    logic             r_reply_seen, n_reply_seen;
    logic [31:0]      r_first_tx_at, n_first_tx_at;

    logic [IDX_W-1:0] next_index;
    logic [IDX_W-1:0] send_index;
    logic [31:0]      since_attempt;
    logic [31:0]      since_request;
    logic [31:0]      since_reply;
    logic [31:0]      since_first_tx;
    logic             gap_ok;
    logic             backing_off;
    logic             timed_out;
    logic [2:0]       expect_len;
    logic [7:0]       data_len;
    logic             frame_ok;
    logic             try_send;
    logic             advance;
    logic             send;
    logic             link_lost;

    // Elapsed times, all modulo 2^32.
    assign since_attempt = i_item.now_ms - r_last_attempt_at;
    assign since_request = i_item.now_ms - r_requested_at;
    assign gap_ok        = since_attempt >= {16'd0, i_cfg.min_gap_ms};
    assign backing_off   = (r_fail_count != 16'd0) &&
                           (since_attempt < {16'd0, i_cfg.backoff_ms});
    assign timed_out     = since_request >= {16'd0, i_cfg.reply_timeout_ms};
    assign next_index    = (r_poll_index == LAST_IDX) ? '0 : r_poll_index + 1'b1;

    // Reply frame checks against the PID currently polled.
    assign expect_len = obd2rr_pkg::poll_len(r_poll_index);
    assign data_len   = (i_item.pci_byte >= obd2rr_pkg::PCI_OVERHEAD) ?
                        i_item.pci_byte - obd2rr_pkg::PCI_OVERHEAD : 8'd0;
    assign frame_ok   = (i_item.frame_ident == {18'd0, i_cfg.reply_id}) &&
                        !i_item.frame_extended && !i_item.frame_remote &&
                        ({1'b0, i_item.frame_bytes} >=
                         obd2rr_pkg::HEADER_BYTES + {2'b00, expect_len}) &&
                        (i_item.service_byte == obd2rr_pkg::SVC_RESPONSE) &&
                        (i_item.pid_byte == obd2rr_pkg::poll_pid(r_poll_index)) &&
                        (data_len == {5'd0, expect_len});

    // Decide whether this tick moves on to the next PID and tries a send.
    always_comb begin
        advance  = 1'b0;
        try_send = 1'b0;
        if (!r_awaiting) begin
            try_send = !backing_off;
        end else if (!i_item.frame_present) begin
            advance  = timed_out;
            try_send = timed_out;
        end else begin
            advance  = frame_ok;
            try_send = frame_ok;
        end
    end

    assign send       = try_send && gap_ok;
    assign send_index = advance ? next_index : r_poll_index;

    // Next state of the poller.
    always_comb begin
        n_poll_index      = r_poll_index;
        n_awaiting        = r_awaiting;
        n_requested_at    = r_requested_at;
        n_fail_count      = r_fail_count;
        n_last_attempt_at = r_last_attempt_at;
        n_last_reply_at   = r_last_reply_at;
        n_reply_seen      = r_reply_seen;
        n_first_tx_at     = r_first_tx_at;

        if (advance) begin
            n_poll_index = next_index;
        end
        if (send) begin
            n_last_attempt_at = i_item.now_ms;
            if (i_item.tx_accepted) begin
                n_fail_count = 16'd0;
                if (r_first_tx_at == 32'd0) begin
                    n_first_tx_at = i_item.now_ms;
                end
            end else if (r_fail_count != obd2rr_pkg::FAIL_SAT) begin
                n_fail_count = r_fail_count + 16'd1;
            end
        end
        if (send && i_item.tx_accepted) begin
            n_requested_at = i_item.now_ms;
            n_awaiting     = 1'b1;
        end else if (advance) begin
            n_awaiting = 1'b0;
        end
        if (r_awaiting && i_item.frame_present && frame_ok) begin
            n_last_reply_at = i_item.now_ms;
            n_reply_seen    = 1'b1;
        end
    end

    // Link-loss detectors, judged on the state after this tick.
    assign since_reply    = i_item.now_ms - n_last_reply_at;
    assign since_first_tx = i_item.now_ms - n_first_tx_at;
    always_comb begin
        if (n_fail_count >= i_cfg.fail_limit) begin
            link_lost = 1'b1;
        end else if (n_reply_seen) begin
            link_lost = since_reply > i_cfg.silence_ms;
        end else begin
            link_lost = (n_first_tx_at != 32'd0) && (since_first_tx > i_cfg.no_reply_ms);
        end
    end

    // Result item for this tick.
    always_comb begin
        o_result                 = '0;
        o_result.tx_request      = send;
        o_result.tx_pid          = send ? obd2rr_pkg::poll_pid(send_index) : 8'd0;
        if (r_awaiting && i_item.frame_present && frame_ok) begin
            o_result.reading_valid   = 1'b1;
            o_result.reading_pid     = obd2rr_pkg::poll_pid(r_poll_index);
            o_result.reading_payload = i_item.frame_payload &
                                       obd2rr_pkg::payload_mask(expect_len);
        end
        o_result.link_lost       = link_lost;
        o_result.ever_replied    = n_reply_seen;
    end

    // State registers, updated once for each item processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_index      <= '0;
            r_awaiting        <= 1'b0;
            r_requested_at    <= 32'd0;
            r_fail_count      <= 16'd0;
            r_last_attempt_at <= 32'd0;
            r_last_reply_at   <= 32'd0;
            r_reply_seen      <= 1'b0;
            r_first_tx_at     <= 32'd0;
        end else if (i_step) begin
            r_poll_index      <= n_poll_index;
            r_awaiting        <= n_awaiting;
            r_requested_at    <= n_requested_at;
            r_fail_count      <= n_fail_count;
            r_last_attempt_at <= n_last_attempt_at;
            r_last_reply_at   <= n_last_reply_at;
            r_reply_seen      <= n_reply_seen;
            r_first_tx_at     <= n_first_tx_at;
        end
    end

    // A request is only outstanding after an accepted send, which clears failures.
    `OBD2RR_ASSERT_IMP(a_await_no_fail, i_clk, i_rst_n, r_awaiting, r_fail_count == 16'd0)
    // The poll index never leaves the table.
    `OBD2RR_ASSERT_IMP(a_index_range, i_clk, i_rst_n, 1'b1, r_poll_index <= LAST_IDX)
    // An accepted reply marks the link as having answered.
    `OBD2RR_ASSERT_NXT(a_reply_seen, i_clk, i_rst_n, i_step && o_result.reading_valid, r_reply_seen)
    // A send stamps the attempt time with the tick's time.
    `OBD2RR_ASSERT_NXT(a_attempt_stamp, i_clk, i_rst_n, i_step && send,
        r_last_attempt_at == $past(i_item.now_ms))

endmodule

// File: rtl/obd2_round_robin_pid_poller.sv
`timescale 1ns / 1ps

// OBD-II service 01 poller: each input item is one service tick carrying the
// time, an optional received CAN frame and the transmitter's acceptance, and
// each produces exactly one result item with the request to send (02 01 pid),
// any accepted reply payload and the link-loss flag. Items are taken at one
// per clock while the output is not stalled: an input register feeds a single
// pass of compares and 32-bit subtractions that updates the poller state and
// loads the output register, and a stalled output only holds the input side
// once both registers are full. Configuration registers are written through
// the plain write port and take effect on the next item; write them only
// while no item is in flight.
module obd2_round_robin_pid_poller #(
    parameter int POLL_ENTRIES = obd2rr_pkg::POLL_ENTRIES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  obd2rr_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output obd2rr_pkg::t_out_item o_out_item,
    input  logic                  i_cfg_wr_en,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    obd2rr_pkg::t_cfg      r_cfg;
    obd2rr_pkg::t_in_item  r_in_item;
    logic                  r_in_valid;
    obd2rr_pkg::t_out_item r_out_item;
    logic                  r_out_valid;
    obd2rr_pkg::t_out_item result;
    logic                  step;
    logic                  in_take;

    // An item is processed when one is held and the output register is free.
    assign step       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step;
    assign in_take    = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_id         <= obd2rr_pkg::RST_REPLY_ID;
            r_cfg.backoff_ms       <= obd2rr_pkg::RST_BACKOFF_MS;
            r_cfg.min_gap_ms       <= obd2rr_pkg::RST_MIN_GAP_MS;
            r_cfg.reply_timeout_ms <= obd2rr_pkg::RST_REPLY_TMO_MS;
            r_cfg.fail_limit       <= obd2rr_pkg::RST_FAIL_LIMIT;
            r_cfg.silence_ms       <= obd2rr_pkg::RST_SILENCE_MS;
            r_cfg.no_reply_ms      <= obd2rr_pkg::RST_NO_REPLY_MS;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                obd2rr_pkg::CFG_REPLY_ID:     r_cfg.reply_id         <= i_cfg_data[10:0];
                obd2rr_pkg::CFG_BACKOFF_MS:   r_cfg.backoff_ms       <= i_cfg_data[15:0];
                obd2rr_pkg::CFG_MIN_GAP_MS:   r_cfg.min_gap_ms       <= i_cfg_data[15:0];
                obd2rr_pkg::CFG_REPLY_TMO_MS: r_cfg.reply_timeout_ms <= i_cfg_data[15:0];
                obd2rr_pkg::CFG_FAIL_LIMIT:   r_cfg.fail_limit       <= i_cfg_data[15:0];
                obd2rr_pkg::CFG_SILENCE_MS:   r_cfg.silence_ms       <= i_cfg_data;
                obd2rr_pkg::CFG_NO_REPLY_MS:  r_cfg.no_reply_ms      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_in_item;
        end
    end

    // Poller state and per-tick decision logic.
    obd2rr_engine #(
        .POLL_ENTRIES (POLL_ENTRIES)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
